// File: hdl/jsu_pkg.sv
// Package for the JSON string unescaper: input/result codes, group type,
// character constants and small decode helpers. No dependencies.
`default_nettype none

package jsu_pkg;

	// Input action codes
	localparam logic [1:0] ACT_BYTE  = 2'd0;
	localparam logic [1:0] ACT_START = 2'd1;
	localparam logic [1:0] ACT_EOT   = 2'd2;

	// Result kinds
	typedef enum logic [1:0] {
		KIND_BYTE  = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_ERROR = 2'd2
	} kind_t;

	// Characters that steer the decoder
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;

	// UTF-8 lead and continuation marks
	localparam logic [7:0] UTF_CONT  = 8'h80;
	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [15:0] CP_LIM1  = 16'h0080;
	localparam logic [15:0] CP_LIM2  = 16'h0800;

	// Most result beats one input item can cause
	localparam int unsigned MAX_RES = 3;

	// Group of result beats produced by one item
	typedef struct packed {
		logic [1:0]              cnt;
		kind_t [MAX_RES-1:0]     kind;
		logic [MAX_RES-1:0][7:0] data;
	} grp_t;

	// Hex digit value; bit 4 set when the byte is not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		if (b >= 8'h30 && b <= 8'h39)
			v = {1'b0, 4'(b - 8'h30)};
		else if (b >= 8'h61 && b <= 8'h66)
			v = {1'b0, 4'(b - 8'h57)};
		else if (b >= 8'h41 && b <= 8'h46)
			v = {1'b0, 4'(b - 8'h37)};
		else
			v = 5'h10;
		return v;
	endfunction

	// Single-byte escape letter to byte; bit 8 set when the letter is known
	function automatic logic [8:0] esc_map(input logic [7:0] b);
		logic [8:0] r;
		unique case (b)
			8'h22:   r = {1'b1, 8'h22};
			8'h5C:   r = {1'b1, 8'h5C};
			8'h2F:   r = {1'b1, 8'h2F};
			8'h6E:   r = {1'b1, 8'h0A};
			8'h74:   r = {1'b1, 8'h09};
			8'h72:   r = {1'b1, 8'h0D};
			8'h62:   r = {1'b1, 8'h08};
			8'h66:   r = {1'b1, 8'h0C};
			default: r = 9'h000;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: hdl/jsu_if.sv
// Valid/ready channel interfaces for the JSON string unescaper.
`default_nettype none

interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] action;
	logic [7:0] in_byte;

	modport source (output valid, output action, output in_byte, input ready);
	modport sink   (input valid, input action, input in_byte, output ready);
endinterface

interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output kind, output out_byte, output last, input ready);
	modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

`default_nettype wire

// File: hdl/json_string_unescape.sv
// Top level of the JSON string unescaper.
// Depends on jsu_pkg, jsu_if, jsu_decode and jsu_emit.
`default_nettype none

// Decodes a quoted JSON string one byte per input beat. An item waits in an
// input register, is decoded against the string state, and its results (none,
// one, or up to three UTF-8 bytes for a \u escape) are loaded into a result
// group register that drives the result channel. Items that give zero or one
// result flow at one per cycle while the output is ready; a \u escape that
// expands to two or three UTF-8 bytes holds the input while the group register
// sends its bytes one per cycle while the output is ready. An input beat goes
// through the input register, then the group register, to its first result.
// A new input beat is taken while a finished result still waits on the output.
module json_string_unescape (
	input  wire logic clk,
	input  wire logic arst_n,
	jsu_in_if.sink    item,
	jsu_out_if.source result
);
	import jsu_pkg::*;

	grp_t grp;
	logic grp_load;
	logic grp_free;

	jsu_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_ready (item.ready),
		.action   (item.action),
		.in_byte  (item.in_byte),
		.grp_free (grp_free),
		.grp_load (grp_load),
		.grp      (grp)
	);

	jsu_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.grp_load  (grp_load),
		.grp       (grp),
		.grp_free  (grp_free),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.kind      (result.kind),
		.out_byte  (result.out_byte),
		.last      (result.last)
	);

endmodule

`default_nettype wire

// File: hdl/jsu_decode.sv
// Input register, string state machine and per-item result group decode.
// Depends on jsu_pkg.
`default_nettype none

module jsu_decode (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic [1:0]   action,
	input  wire logic [7:0]   in_byte,
	input  wire logic         grp_free,
	output logic              grp_load,
	output jsu_pkg::grp_t     grp
);
	import jsu_pkg::*;

	typedef enum logic [1:0] {
		M_IDLE = 2'd0,
		M_STR  = 2'd1,
		M_ESC  = 2'd2,
		M_HEX  = 2'd3
	} mode_t;

	mode_t       mode_q, mode_d;
	logic [1:0]  hex_seen_q, hex_seen_d;
	logic [15:0] cp_q, cp_d;

	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [7:0]  byte_s1;

	logic        adv;
	logic [4:0]  hv;
	logic [8:0]  esc;
	logic [15:0] cp_new;
	grp_t        g;

	assign hv     = hex_value(byte_s1);
	assign esc    = esc_map(byte_s1);
	assign cp_new = {cp_q[11:0], hv[3:0]};

	// Decode the held item against the current state
	always_comb begin
		mode_d     = mode_q;
		hex_seen_d = hex_seen_q;
		cp_d       = cp_q;
		g          = '0;
		if (action_s1 == ACT_EOT) begin
			if (mode_q != M_IDLE) begin
				g.cnt     = 2'd1;
				g.kind[0] = KIND_ERROR;
				mode_d     = M_IDLE;
				hex_seen_d = '0;
				cp_d       = '0;
			end
		end else if (action_s1 == ACT_START) begin
			if (byte_s1 != CH_QUOTE) begin
				g.cnt     = 2'd1;
				g.kind[0] = KIND_ERROR;
				mode_d    = M_IDLE;
			end else begin
				mode_d = M_STR;
			end
			hex_seen_d = '0;
			cp_d       = '0;
		end else if (action_s1 == ACT_BYTE) begin
			unique case (mode_q)
				M_IDLE: begin
				end
				M_STR: begin
					if (byte_s1 == CH_QUOTE) begin
						g.cnt     = 2'd1;
						g.kind[0] = KIND_DONE;
						mode_d    = M_IDLE;
					end else if (byte_s1 == CH_BSLASH) begin
						mode_d = M_ESC;
					end else begin
						g.cnt     = 2'd1;
						g.data[0] = byte_s1;
					end
				end
				M_ESC: begin
					if (byte_s1 == CH_U) begin
						mode_d     = M_HEX;
						hex_seen_d = '0;
						cp_d       = '0;
					end else if (esc[8]) begin
						g.cnt     = 2'd1;
						g.data[0] = esc[7:0];
						mode_d    = M_STR;
					end else begin
						g.cnt      = 2'd1;
						g.kind[0]  = KIND_ERROR;
						mode_d     = M_IDLE;
						hex_seen_d = '0;
						cp_d       = '0;
					end
				end
				M_HEX: begin
					if (hv[4]) begin
						g.cnt      = 2'd1;
						g.kind[0]  = KIND_ERROR;
						mode_d     = M_IDLE;
						hex_seen_d = '0;
						cp_d       = '0;
					end else if (hex_seen_q != 2'd3) begin
						cp_d       = cp_new;
						hex_seen_d = hex_seen_q + 2'd1;
					end else begin
						// Encode the gathered code point as UTF-8
						if (cp_new < CP_LIM1) begin
							g.cnt     = 2'd1;
							g.data[0] = cp_new[7:0];
						end else if (cp_new < CP_LIM2) begin
							g.cnt     = 2'd2;
							g.data[0] = UTF_LEAD2 | {3'b000, cp_new[10:6]};
							g.data[1] = UTF_CONT | {2'b00, cp_new[5:0]};
						end else begin
							g.cnt     = 2'd3;
							g.data[0] = UTF_LEAD3 | {4'h0, cp_new[15:12]};
							g.data[1] = UTF_CONT | {2'b00, cp_new[11:6]};
							g.data[2] = UTF_CONT | {2'b00, cp_new[5:0]};
						end
						mode_d     = M_STR;
						hex_seen_d = '0;
						cp_d       = '0;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Advance when nothing is produced or the group stage can take it
	assign adv      = valid_s1 && (g.cnt == 2'd0 || grp_free);
	assign in_ready = !valid_s1 || adv;
	assign grp_load = adv && (g.cnt != 2'd0);
	assign grp      = g;

	// Hold the input beat and the string state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			mode_q     <= M_IDLE;
			hex_seen_q <= '0;
			cp_q       <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (adv) begin
				mode_q     <= mode_d;
				hex_seen_q <= hex_seen_d;
				cp_q       <= cp_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1 <= action;
			byte_s1   <= in_byte;
		end
	end

endmodule

`default_nettype wire

// File: hdl/jsu_emit.sv
// Result group register that sends one result beat per cycle while the output is ready.
// Depends on jsu_pkg.
`default_nettype none

module jsu_emit (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          grp_load,
	input  wire jsu_pkg::grp_t grp,
	output logic               grp_free,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [1:0]         kind,
	output logic [7:0]         out_byte,
	output logic               last
);
	import jsu_pkg::*;

	logic       grp_valid_q;
	grp_t       grp_q;
	logic [1:0] idx_q;
	logic       at_last;
	logic       fire;

	assign at_last   = (idx_q == grp_q.cnt - 2'd1);
	assign fire      = grp_valid_q && out_ready;
	assign grp_free  = !grp_valid_q || (out_ready && at_last);

	assign out_valid = grp_valid_q;
	assign kind      = grp_q.kind[idx_q];
	assign out_byte  = grp_q.data[idx_q];
	assign last      = at_last;

	// Step through the group, reload when the last beat leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (grp_free) begin
			grp_valid_q <= grp_load;
			idx_q       <= '0;
		end else if (fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (grp_free && grp_load)
			grp_q <= grp;
	end

endmodule

`default_nettype wire

// File: hdl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg.
`default_nettype none

module jsu_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] kind,
	input wire logic [7:0] out_byte,
	input wire logic       last
);
	import jsu_pkg::*;

	// Done and error beats stand alone and carry a zero byte
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind == KIND_DONE || kind == KIND_ERROR) |-> last && out_byte == 8'h00)
		else $error("status beat not single or byte not zero");

	// A multi-byte group continues on the very next cycle
	a_group_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_valid && kind == KIND_BYTE)
		else $error("group of result beats broken");

	// Continuation beats follow a UTF-8 lead byte
	a_utf_cont: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !last |=> out_byte[7:6] == 2'b10)
		else $error("non-continuation byte inside a group");

	// Stalled beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_byte)
			&& $stable(last))
		else $error("stalled result beat changed");

endmodule

bind json_string_unescape jsu_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.kind      (result.kind),
	.out_byte  (result.out_byte),
	.last      (result.last)
);

`default_nettype wire
